[rtl/mes_pkg.sv]
package mes_pkg;

    // Upper bound on argument bytes, and the number of argument fields present
    localparam int MAX_ARGS   = 2;
    localparam int ARG_FIELDS = 2;
    localparam logic [1:0] ARG_LIMIT =
        2'((MAX_ARGS < ARG_FIELDS) ? MAX_ARGS : ARG_FIELDS);

    localparam logic [31:0] DELTA_SAT  = 32'h0FFF_FFFF;
    localparam logic [27:0] LIM_4BYTE  = 28'h01F_FFFF;
    localparam logic [27:0] LIM_3BYTE  = 28'h000_3FFF;
    localparam logic [27:0] LIM_2BYTE  = 28'h000_007F;
    localparam logic [3:0]  CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0]  CMD_NOTE_OFF = 4'h8;
    localparam logic [7:0]  CONT_BIT   = 8'h80;

    // Event queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Classified event, as the back end needs it
    typedef struct packed {
        logic        fail;     // room too small: one failure result
        logic [27:0] delta;    // saturated delta
        logic [1:0]  nd_m1;    // delta bytes minus one
        logic [7:0]  status;   // status after note-off rewrite
        logic [1:0]  count;    // argument bytes, saturated
        logic [7:0]  arg0;
        logic [7:0]  arg1;
    } t_event;

endpackage

[rtl/midi_event_serializer.sv]
// With the queue empty, an accepted item is written into the event queue, and its
//   first byte is then registered in the back end before it reaches the result ports.
// Throughput: one result per cycle while the queue holds an item; an item is one
//   byte (failure) to seven bytes on the back end's byte counter, so the byte sequencer sets the item rate.
// busy rises while the two-entry event queue is full.
// Reset (synchronous, active low) empties the queue and drops the strobe.
module midi_event_serializer
    import mes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_delta_frames,
    input  logic [7:0]  i_status_value,
    input  logic [1:0]  i_arg_count,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_room,
    output logic        o_strobe,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_too_small
);

    t_event w_front_event;  // classified item from the front end
    t_event w_head_event;   // oldest queued item, being serialised
    logic   w_push;
    logic   w_pop;
    logic   w_empty;
    logic   w_full;

    // Item taken whenever the queue has room, even while bytes are streaming
    assign busy   = w_full;
    assign w_push = start && !w_full;

    // Front: saturate delta, size the VLQ, rewrite note-on, check room
    mes_front u_front (
        .i_delta_frames (i_delta_frames),
        .i_status_value (i_status_value),
        .i_arg_count    (i_arg_count),
        .i_arg_first    (i_arg_first),
        .i_arg_second   (i_arg_second),
        .i_room         (i_room),
        .o_event        (w_front_event)
    );

    // Short queue decouples acceptance from byte output
    mes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_event (w_front_event),
        .i_pop   (w_pop),
        .o_event (w_head_event),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Back: one byte per cycle while the queue holds an item, popping the item with its last byte
    mes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_empty),
        .i_event     (w_head_event),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_too_small (o_too_small)
    );

    // Failure result is a lone zero byte closing the item
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_too_small |-> o_last_byte && o_out_byte == 8'd0)
        else $error("failure result malformed");

    // Bytes of one item come out without gaps
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |=> o_strobe)
        else $error("gap inside an item");

    // Queue fills only through an accepted item
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");

    // Nothing popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue underflow");

endmodule

[rtl/mes_front.sv]
module mes_front
    import mes_pkg::*;
(
    input  logic [31:0] i_delta_frames,
    input  logic [7:0]  i_status_value,
    input  logic [1:0]  i_arg_count,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_room,
    output t_event      o_event
);

    logic [27:0] w_delta;
    logic [1:0]  w_nd_m1;
    logic [1:0]  w_count;
    logic [7:0]  w_status;
    logic [2:0]  w_total;

    always_comb begin
        w_delta = (|i_delta_frames[31:28]) ? DELTA_SAT[27:0] : i_delta_frames[27:0];

        priority if (w_delta > LIM_4BYTE) begin
            w_nd_m1 = 2'd3;
        end else if (w_delta > LIM_3BYTE) begin
            w_nd_m1 = 2'd2;
        end else if (w_delta > LIM_2BYTE) begin
            w_nd_m1 = 2'd1;
        end else begin
            w_nd_m1 = 2'd0;
        end

        w_count = (i_arg_count > ARG_LIMIT) ? ARG_LIMIT : i_arg_count;

        // zero-velocity note-on goes out as note-off
        if (i_status_value[7:4] == CMD_NOTE_ON && w_count == 2'd2 && i_arg_second == 8'd0) begin
            w_status = {CMD_NOTE_OFF, i_status_value[3:0]};
        end else begin
            w_status = i_status_value;
        end

        w_total = 3'({1'b0, w_nd_m1}) + 3'd2 + 3'({1'b0, w_count});

        o_event.fail   = (i_room < {5'd0, w_total});
        o_event.delta  = w_delta;
        o_event.nd_m1  = w_nd_m1;
        o_event.status = w_status;
        o_event.count  = w_count;
        o_event.arg0   = i_arg_first;
        o_event.arg1   = i_arg_second;
    end

endmodule

[rtl/mes_queue.sv]
module mes_queue
    import mes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    input  logic   i_pop,
    output t_event o_event,
    output logic   o_empty,
    output logic   o_full
);

    t_event            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_event = r_mem[r_rd_ptr];

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + Q_CW'(i_push) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

endmodule

[rtl/mes_back.sv]
module mes_back
    import mes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_event     i_event,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic       o_too_small
);

    logic [2:0] r_idx, n_idx;
    logic       r_strobe;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_small;
    logic [2:0] w_total_m1;
    logic [1:0] w_rem;
    logic [6:0] w_group;

    always_comb begin
        w_total_m1 = 3'({1'b0, i_event.nd_m1}) + 3'd1 + 3'({1'b0, i_event.count});
        w_rem      = i_event.nd_m1 - r_idx[1:0];

        unique case (w_rem)
            2'd0: w_group = i_event.delta[6:0];
            2'd1: w_group = i_event.delta[13:7];
            2'd2: w_group = i_event.delta[20:14];
            2'd3: w_group = i_event.delta[27:21];
            default: w_group = '0;
        endcase

        priority if (i_event.fail) begin
            n_byte = 8'd0;
        end else if (r_idx <= 3'({1'b0, i_event.nd_m1})) begin
            n_byte = {(w_rem != 2'd0), w_group};
        end else if (r_idx == 3'({1'b0, i_event.nd_m1}) + 3'd1) begin
            n_byte = i_event.status;
        end else if (r_idx == 3'({1'b0, i_event.nd_m1}) + 3'd2) begin
            n_byte = i_event.arg0;
        end else begin
            n_byte = i_event.arg1;
        end

        n_last = i_event.fail || (r_idx == w_total_m1);
        o_pop  = i_valid && n_last;
        n_idx  = !i_valid ? r_idx : (n_last ? 3'd0 : r_idx + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_byte  <= n_byte;
            r_last  <= n_last;
            r_small <= i_event.fail;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;
    assign o_too_small = r_small;

endmodule

[bench/mes_stream_checker.sv]
`timescale 1ns / 1ps

module mes_stream_checker
    import mes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_delta_frames,
    input  logic [7:0]  i_status_value,
    input  logic [1:0]  i_arg_count,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_room,
    input  logic        i_strobe,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_byte,
    input  logic        i_too_small,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_events,
    output int          o_bytes,
    output int          o_refusals
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       too_small;
    } t_serial_byte;

    t_serial_byte serial_bytes_due[$];
    int mismatches = 0;
    int events     = 0;
    int bytes_seen = 0;
    int refusals   = 0;

    assign o_mismatches = mismatches;
    assign o_events     = events;
    assign o_bytes      = bytes_seen;
    assign o_refusals   = refusals;

    // Byte stream of one event: delta as big-endian VLQ, status, arguments
    task automatic serialise_event(input logic [31:0] delta, input logic [7:0] status,
                                   input logic [1:0] count, input logic [7:0] arg0,
                                   input logic [7:0] arg1, input logic [7:0] room);
        logic [27:0] sat_delta;
        logic [1:0]  n_args;
        logic [7:0]  sent_status;
        logic [7:0]  vlq_byte;
        int          n_delta;
        int          total;
        n_args    = (count > ARG_LIMIT) ? ARG_LIMIT : count;
        sat_delta = (delta > DELTA_SAT) ? DELTA_SAT[27:0] : delta[27:0];
        if (sat_delta > LIM_4BYTE)
            n_delta = 4;
        else if (sat_delta > LIM_3BYTE)
            n_delta = 3;
        else if (sat_delta > LIM_2BYTE)
            n_delta = 2;
        else
            n_delta = 1;
        sent_status = status;
        if (status[7:4] == CMD_NOTE_ON && n_args >= 2'd2 && arg1 == 8'h00)
            sent_status = {CMD_NOTE_OFF, status[3:0]};
        total = n_delta + 1 + int'(n_args);
        events++;
        if (int'(room) < total) begin
            refusals++;
            serial_bytes_due.push_back('{8'h00, 1'b1, 1'b1});
        end else begin
            for (int i = 0; i < n_delta; i++) begin
                vlq_byte = {1'b0, 7'(sat_delta >> (7 * (n_delta - 1 - i)))};
                if (i < n_delta - 1)
                    vlq_byte = vlq_byte | CONT_BIT;
                serial_bytes_due.push_back('{vlq_byte, 1'b0, 1'b0});
            end
            serial_bytes_due.push_back('{sent_status, n_args == 2'd0, 1'b0});
            if (n_args >= 2'd1)
                serial_bytes_due.push_back('{arg0, n_args == 2'd1, 1'b0});
            if (n_args >= 2'd2)
                serial_bytes_due.push_back('{arg1, 1'b1, 1'b0});
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_serial_byte want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                serialise_event(i_delta_frames, i_status_value, i_arg_count,
                                i_arg_first, i_arg_second, i_room);
            if (i_strobe) begin
                bytes_seen++;
                if (serial_bytes_due.size() == 0) begin
                    $error("unexpected result: out_byte %0h last_byte %0b too_small %0b",
                           i_out_byte, i_last_byte, i_too_small);
                    mismatches++;
                end else begin
                    want = serial_bytes_due.pop_front();
                    if (i_out_byte !== want.value) begin
                        $error("out_byte: expected %0h, got %0h", want.value, i_out_byte);
                        mismatches++;
                    end
                    if (i_last_byte !== want.last) begin
                        $error("last_byte: expected %0b, got %0b", want.last, i_last_byte);
                        mismatches++;
                    end
                    if (i_too_small !== want.too_small) begin
                        $error("too_small: expected %0b, got %0b", want.too_small,
                               i_too_small);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= serial_bytes_due.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the MIDI event serialiser. Items go in through the
// start/busy handshake; the checker beside the block predicts every byte.
module tb;
    import mes_pkg::*;

    localparam int RANDOM_ITEMS = 180;
    localparam int CYCLE_LIMIT  = 200_000;  // far beyond a slow clean run
    localparam int DRAIN_CYCLES = 8;        // margin after the checker has drained

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] delta_frames;
    logic [7:0]  status_value;
    logic [1:0]  arg_count;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [7:0]  room;
    logic        strobe;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic        too_small;

    int mismatches;
    int bytes_pending;
    int events_seen;
    int bytes_seen;
    int refusals_seen;
    int cycles = 0;
    int items_sent;

    midi_event_serializer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_delta_frames (delta_frames),
        .i_status_value (status_value),
        .i_arg_count    (arg_count),
        .i_arg_first    (arg_first),
        .i_arg_second   (arg_second),
        .i_room         (room),
        .o_strobe       (strobe),
        .o_out_byte     (out_byte),
        .o_last_byte    (last_byte),
        .o_too_small    (too_small)
    );

    mes_stream_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_delta_frames (delta_frames),
        .i_status_value (status_value),
        .i_arg_count    (arg_count),
        .i_arg_first    (arg_first),
        .i_arg_second   (arg_second),
        .i_room         (room),
        .i_strobe       (strobe),
        .i_out_byte     (out_byte),
        .i_last_byte    (last_byte),
        .i_too_small    (too_small),
        .o_mismatches   (mismatches),
        .o_pending      (bytes_pending),
        .o_events       (events_seen),
        .o_bytes        (bytes_seen),
        .o_refusals     (refusals_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or lost bytes end the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one item and hold it until an edge sees start high, busy low.
    // start stays high afterwards; the caller lowers it through idle_for.
    task automatic send_event(input logic [31:0] delta, input logic [7:0] status,
                              input logic [1:0] count, input logic [7:0] arg0,
                              input logic [7:0] arg1, input logic [7:0] avail);
        start        <= 1'b1;
        delta_frames <= delta;
        status_value <= status;
        arg_count    <= count;
        arg_first    <= arg0;
        arg_second   <= arg1;
        room         <= avail;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Idle gap, n >= 1; the fields carry junk meanwhile, which must be ignored
    task automatic idle_for(input int n);
        start        <= 1'b0;
        delta_frames <= $urandom();
        status_value <= 8'($urandom());
        arg_count    <= 2'($urandom());
        arg_first    <= 8'($urandom());
        arg_second   <= 8'($urandom());
        room         <= 8'($urandom());
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained;
        do @(posedge i_clk); while (bytes_pending != 0);
    endtask

    // Mostly well-formed events: delta spread over every VLQ length, many
    // note-ons, room often near the event length so both outcomes occur.
    task automatic send_random_event;
        logic [31:0] delta;
        logic [7:0]  status;
        logic [7:0]  arg1;
        logic [7:0]  avail;
        case ($urandom_range(0, 5))
            0: delta = $urandom_range(0, 32'h7F);
            1: delta = $urandom_range(32'h80, 32'h3FFF);
            2: delta = $urandom_range(32'h4000, 32'h1F_FFFF);
            3: delta = $urandom_range(32'h20_0000, 32'hFFF_FFFF);
            4: delta = $urandom();
            default: delta = $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1))
            status = {CMD_NOTE_ON, 4'($urandom())};
        else
            status = 8'($urandom());
        arg1 = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom());
        case ($urandom_range(0, 3))
            0: avail = 8'hFF;
            1: avail = 8'($urandom());
            default: avail = 8'($urandom_range(0, 8));
        endcase
        send_event(delta, status, 2'($urandom()), 8'($urandom()), arg1, avail);
    endtask

    initial begin : stimulus
        int burst;
        int gap;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        delta_frames <= '0;
        status_value <= '0;
        arg_count    <= '0;
        arg_first    <= '0;
        arg_second   <= '0;
        room         <= '0;
        items_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Delta lengths at each VLQ boundary, then saturation above 28 bits
        send_event(32'h0000_0000, {CMD_NOTE_ON, 4'h0}, 2'd2, 8'd60, 8'd100, 8'hFF);
        send_event(32'h0000_007F, 8'hB3, 2'd2, 8'h07, 8'h7F, 8'hFF);
        send_event(32'h0000_0080, 8'hC1, 2'd1, 8'h05, 8'h00, 8'hFF);
        send_event(32'h0000_3FFF, 8'hE0, 2'd2, 8'h00, 8'h40, 8'hFF);
        idle_for(3);
        send_event(32'h0000_4000, 8'hA2, 2'd2, 8'h3C, 8'h11, 8'hFF);
        send_event(32'h001F_FFFF, 8'hD5, 2'd1, 8'h22, 8'h33, 8'hFF);
        send_event(32'h0020_0000, 8'h80, 2'd2, 8'h3C, 8'h00, 8'hFF);
        send_event(32'h0FFF_FFFF, 8'hF8, 2'd0, 8'h00, 8'h00, 8'hFF);
        send_event(32'h1000_0000, 8'hFF, 2'd0, 8'hFF, 8'hFF, 8'hFF);
        send_event(32'hFFFF_FFFF, 8'hFF, 2'd2, 8'hFF, 8'hFF, 8'hFF);
        // Note-on with zero velocity turns into note-off; without a velocity it does not
        send_event(32'h0000_0010, {CMD_NOTE_ON, 4'hF}, 2'd2, 8'd64, 8'h00, 8'hFF);
        send_event(32'h0000_0010, {CMD_NOTE_ON, 4'h3}, 2'd1, 8'd64, 8'h00, 8'hFF);
        send_event(32'h0000_0010, {CMD_NOTE_ON, 4'h3}, 2'd3, 8'd64, 8'h00, 8'hFF);
        // Argument count of three is clipped to two
        send_event(32'h0000_0001, 8'h90, 2'd3, 8'hAA, 8'h55, 8'hFF);
        send_event(32'h0000_0000, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF);
        // Room exactly the event length, one short, and none at all
        send_event(32'h0020_0000, 8'h91, 2'd2, 8'd1, 8'd2, 8'd7);
        send_event(32'h0020_0000, 8'h91, 2'd2, 8'd1, 8'd2, 8'd6);
        send_event(32'h0000_0000, 8'hC0, 2'd0, 8'd0, 8'd0, 8'd1);
        send_event(32'h0000_0000, 8'hC0, 2'd0, 8'd0, 8'd0, 8'd0);
        send_event(32'hFFFF_FFFF, 8'h9A, 2'd2, 8'h7F, 8'h00, 8'd0);

        // Hold off until the block has emitted everything
        start <= 1'b0;
        wait_drained();

        // Random bursts of back-to-back items, most separated by random gaps
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
                send_random_event();
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
                idle_for(gap);
        end

        start <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d events over all delta lengths, %0d refused for room,",
                 events_seen, refusals_seen);
        $display("%0d serialised bytes checked", bytes_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/mes_pkg.sv
rtl/mes_front.sv
rtl/mes_queue.sv
rtl/mes_back.sv
rtl/midi_event_serializer.sv
bench/mes_stream_checker.sv
bench/tb.sv
